// ----- hw/rtl/salc_pkg.sv -----
`timescale 1ns / 1ps

package salc_pkg;

	localparam int ADDR_W    = 32;
	localparam int WAY_OUT_W = 2;
	localparam int SET_OUT_W = 6;
	localparam int CNT_W     = 32;

	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic [SET_OUT_W-1:0] set_index;
		count_t               hit_count;
		count_t               miss_count;
	} result_t;

endpackage

// ----- hw/rtl/salc_addr_if.sv -----
`timescale 1ns / 1ps

interface salc_addr_if;
	logic                         valid;
	logic                         ready;
	logic [salc_pkg::ADDR_W-1:0]  address;

	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);
endinterface

// ----- hw/rtl/salc_result_if.sv -----
`timescale 1ns / 1ps

interface salc_result_if;
	logic                           valid;
	logic                           ready;
	logic                           hit;
	logic [salc_pkg::WAY_OUT_W-1:0] way;
	logic [salc_pkg::SET_OUT_W-1:0] set_index;
	salc_pkg::count_t               hit_count;
	salc_pkg::count_t               miss_count;

	modport source (output valid, output hit, output way, output set_index,
		output hit_count, output miss_count, input ready);
	modport sink   (input valid, input hit, input way, input set_index,
		input hit_count, input miss_count, output ready);
endinterface

// ----- hw/rtl/set_assoc_lru_cache_lookup_top.sv -----
// Tag directory of a set-associative cache with least-recently-used replacement. One address
// transfer is accepted every cycle unless the input stalls; its result is offered from the output
// register (the set's tag and rank row is read into the input register at the accepting edge, and
// the tag compare and update are written into the output register). A held output only stalls
// the input once both stages are full. Tags and recency ranks live in a memory of one row per
// set, written back in the cycle the result is registered, with a one-entry bypass for a lookup
// to the set just written. Valid bits are flip-flops cleared by reset, so the block is usable
// straight out of reset with no clearing pass. The hit and miss totals saturate at their maximum.
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup_top #(
	parameter int WAYS         = 4,
	parameter int INDEX_BITS   = 6,
	parameter int OFFSET_BITS  = 5,
	parameter int ADDRESS_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	salc_addr_if.sink          req,
	salc_result_if.source      rsp
);

	localparam int AW       = salc_pkg::ADDR_W;
	localparam int NUM_SETS = 1 << INDEX_BITS;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W   = WAY_W;
	localparam int NV_W     = $clog2(WAYS + 1);
	localparam int TAG_RAW  = ((ADDRESS_BITS < AW) ? ADDRESS_BITS : AW)
		- OFFSET_BITS - INDEX_BITS;
	localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam logic [AW-1:0] ADDR_MASK = (ADDRESS_BITS >= AW) ? {AW{1'b1}} :
		AW'((64'd1 << ADDRESS_BITS) - 64'd1);

	typedef struct packed {
		logic [WAYS-1:0][TAG_W-1:0]  tag;
		logic [WAYS-1:0][RANK_W-1:0] rank;
	} row_t;

	row_t                         mem_q [NUM_SETS];
	logic [NUM_SETS-1:0][WAYS-1:0] valid_q;

	logic                  v_s1;
	logic [AW-1:0]         addr_s1;
	row_t                  rd_row_s1;
	logic                  fwd_v_q;
	logic [INDEX_BITS-1:0] fwd_set_q;
	row_t                  fwd_row_q;
	salc_pkg::count_t      hit_cnt_q;
	salc_pkg::count_t      miss_cnt_q;
	logic                  out_v_q;
	salc_pkg::result_t     out_q;

	logic [AW-1:0]         in_masked;
	logic [INDEX_BITS-1:0] in_set;
	logic [INDEX_BITS-1:0] set_s1;
	logic [TAG_W-1:0]      tag_s1;
	logic                  in_acc;
	logic                  adv;
	row_t                  row_cur;
	row_t                  new_row;
	logic [WAYS-1:0]       vld;
	logic [WAYS-1:0]       new_vld;
	logic [WAYS-1:0]       match;
	logic [NV_W-1:0]       nvalid;
	logic                  hit;
	logic                  any_inv;
	logic                  lru_found;
	logic [WAY_W-1:0]      hit_way;
	logic [WAY_W-1:0]      inv_way;
	logic [WAY_W-1:0]      lru_way;
	logic [WAY_W-1:0]      sel_way;
	logic [RANK_W-1:0]     hit_rank;
	salc_pkg::count_t      hit_cnt_d;
	salc_pkg::count_t      miss_cnt_d;

	assign in_masked = req.address & ADDR_MASK;
	assign in_set    = INDEX_BITS'(in_masked >> OFFSET_BITS);
	assign set_s1    = INDEX_BITS'(addr_s1 >> OFFSET_BITS);
	assign tag_s1    = (TAG_RAW > 0) ? TAG_W'(addr_s1 >> (OFFSET_BITS + INDEX_BITS)) : '0;

	assign adv       = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign in_acc    = req.valid && req.ready;

	always_comb begin
		row_cur   = (fwd_v_q && (fwd_set_q == set_s1)) ? fwd_row_q : rd_row_s1;
		vld       = valid_q[set_s1];
		nvalid    = '0;
		hit_way   = '0;
		inv_way   = '0;
		lru_way   = '0;
		lru_found = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			match[i] = vld[i] && (row_cur.tag[i] == tag_s1);
			nvalid   = nvalid + NV_W'(vld[i]);
			if (match[i]) begin
				hit_way = WAY_W'(i);
			end
			if (!lru_found && (row_cur.rank[i] == '0)) begin
				lru_way   = WAY_W'(i);
				lru_found = 1'b1;
			end
		end
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (!vld[i]) begin
				inv_way = WAY_W'(i);
			end
		end
		hit      = |match;
		any_inv  = ~&vld;
		hit_rank = row_cur.rank[hit_way];
		new_row  = row_cur;
		new_vld  = vld;
		if (hit) begin
			sel_way = hit_way;
			for (int i = 0; i < WAYS; i++) begin
				if (vld[i] && (row_cur.rank[i] > hit_rank)) begin
					new_row.rank[i] = row_cur.rank[i] - RANK_W'(1);
				end
			end
			new_row.rank[hit_way] = RANK_W'(nvalid - NV_W'(1));
		end else if (any_inv) begin
			sel_way                = inv_way;
			new_row.rank[inv_way]  = RANK_W'(nvalid);
			new_row.tag[inv_way]   = tag_s1;
			new_vld[inv_way]       = 1'b1;
		end else begin
			sel_way = lru_way;
			for (int i = 0; i < WAYS; i++) begin
				if (row_cur.rank[i] != '0) begin
					new_row.rank[i] = row_cur.rank[i] - RANK_W'(1);
				end
			end
			new_row.rank[lru_way] = RANK_W'(WAYS - 1);
			new_row.tag[lru_way]  = tag_s1;
		end
		hit_cnt_d  = (hit && (hit_cnt_q != '1)) ? hit_cnt_q + 1'b1 : hit_cnt_q;
		miss_cnt_d = (!hit && (miss_cnt_q != '1)) ? miss_cnt_q + 1'b1 : miss_cnt_q;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_row_s1 <= mem_q[in_set];
			addr_s1   <= in_masked;
		end
		if (adv) begin
			mem_q[set_s1] <= new_row;
			fwd_set_q     <= set_s1;
			fwd_row_q     <= new_row;
			out_q         <= '{hit: hit, way: salc_pkg::WAY_OUT_W'(sel_way),
				set_index: salc_pkg::SET_OUT_W'(set_s1),
				hit_count: hit_cnt_d, miss_count: miss_cnt_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			fwd_v_q    <= 1'b0;
			out_v_q    <= 1'b0;
			valid_q    <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (adv) begin
				fwd_v_q         <= 1'b1;
				valid_q[set_s1] <= new_vld;
				hit_cnt_q       <= hit_cnt_d;
				miss_cnt_q      <= miss_cnt_d;
				out_v_q         <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.hit        = out_q.hit;
	assign rsp.way        = out_q.way;
	assign rsp.set_index  = out_q.set_index;
	assign rsp.hit_count  = out_q.hit_count;
	assign rsp.miss_count = out_q.miss_count;

	a_tag_unique: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $onehot0(match))
		else $error("Tag is valid in more than one way of a set.");

	a_way_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_q[$past(set_s1)][$past(sel_way)])
		else $error("Selected way is not valid after the update.");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && hit && (hit_cnt_q != '1) |=> hit_cnt_q == $past(hit_cnt_q) + 1'b1)
		else $error("Hit total did not advance on a hit.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(addr_s1))
		else $error("Stalled lookup was lost or changed.");

endmodule
